FILE: rtl/abre_pkg.sv
// Shared widths, constants and types of the adaptive binary range encoder.
package abre_pkg;

  localparam int CTX_W     = 9;
  localparam int SHIFT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 32;
  localparam int WEIGHT_W  = 12;
  localparam int RANGE_W   = 32;
  localparam int LOW_W     = 33;
  localparam int STEP_W    = 3;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_INIT     = 12'h800;
  localparam logic [WEIGHT_W:0]   WEIGHT_ONE      = 13'h1000;
  localparam logic [RANGE_W-1:0]  RANGE_INIT      = 32'hffff_ffff;
  localparam logic [RANGE_W-1:0]  RANGE_TOP       = 32'h0100_0000;
  localparam logic [RANGE_W-1:0]  RANGE_FLOOR     = 32'h0000_1000;
  localparam logic [RANGE_W-1:0]  LOW_FLUSH_LIMIT = 32'hff00_0000;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 32'hffff_ffff;
  localparam logic [BYTE_W-1:0]   CACHE_INIT      = 8'hff;
  localparam logic [BYTE_W-1:0]   FILL_NO_CARRY   = 8'hff;
  localparam logic [BYTE_W-1:0]   FILL_CARRY      = 8'h00;
  localparam logic [STEP_W-1:0]   FINISH_SHIFTS   = 3'd5;
  localparam logic [STEP_W-1:0]   ENCODE_SHIFTS   = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TYPE_SHIFT            = 3'd0,
    REG_LITERAL_SHIFT         = 3'd1,
    REG_LENGTH_PREFIX_SHIFT   = 3'd2,
    REG_LENGTH_SUFFIX_SHIFT   = 3'd3,
    REG_DISTANCE_PREFIX_SHIFT = 3'd4,
    REG_DISTANCE_SUFFIX_SHIFT = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_UPDATE,
    ST_SHIFT
  } state_t;

endpackage

FILE: rtl/abre_bit_if.sv
// Channel carrying one encode or finish request per transaction.
interface abre_bit_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic                       bit_req;
  logic [abre_pkg::CTX_W-1:0] context_req;

  modport source (output valid, cmd, bit_req, context_req, input ready);
  modport sink   (input valid, cmd, bit_req, context_req, output ready);
endinterface

FILE: rtl/abre_flush_if.sv
// Channel carrying one flush record per transaction.
interface abre_flush_if;
  logic                         valid;
  logic                         ready;
  logic [abre_pkg::BYTE_W-1:0]  head_byte;
  logic [abre_pkg::BYTE_W-1:0]  fill_byte;
  logic [abre_pkg::COUNT_W-1:0] byte_count;
  logic                         last;

  modport source (output valid, head_byte, fill_byte, byte_count, last, input ready);
  modport sink   (input valid, head_byte, fill_byte, byte_count, last, output ready);
endinterface

FILE: rtl/adaptive_binary_range_encoder.sv
// Adaptive binary range encoder: weight memory, range coder and flush record output.
// Encode: weight memory read, 20x12 split multiply and range update in turn, then byte shifts
//   while the range is below RANGE_TOP, then a closing step ends the transaction.
// Finish: five byte shifts, then a clearing pass that rewrites the weight of every context.
// A full holding stage and output register block a shift that would emit a further record,
//   and the end of a transaction while a record is still held; bits.ready is low meanwhile.
// Reset (rst, synchronous): coder and shift registers to initial values, then the clearing pass.
module adaptive_binary_range_encoder #(
  parameter int LITERAL_CONTEXTS = 256,
  parameter int PREFIX_SLOTS     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  abre_bit_if.sink                       bits,
  abre_flush_if.source                   records,
  input  logic                           cfg_we,
  input  logic [abre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abre_pkg::SHIFT_W-1:0]   cfg_data
);

  localparam int TOTAL = LITERAL_CONTEXTS + 4 * PREFIX_SLOTS;
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = abre_pkg::CTX_W;
  localparam int WW    = abre_pkg::WEIGHT_W;
  localparam int SW    = abre_pkg::SHIFT_W;
  localparam int BW    = abre_pkg::BYTE_W;
  localparam int NW    = abre_pkg::COUNT_W;
  localparam int RW    = abre_pkg::RANGE_W;
  localparam int LW    = abre_pkg::LOW_W;
  localparam int PW    = abre_pkg::STEP_W;

  // Group boundaries in context space
  localparam logic [CW-1:0] CTX_TOTAL = CW'(TOTAL);
  localparam logic [CW-1:0] LIT_END   = CW'(LITERAL_CONTEXTS);
  localparam logic [CW-1:0] LP_END    = CW'(LITERAL_CONTEXTS + PREFIX_SLOTS);
  localparam logic [CW-1:0] LS_END    = CW'(LITERAL_CONTEXTS + 2 * PREFIX_SLOTS);
  localparam logic [CW-1:0] DP_END    = CW'(LITERAL_CONTEXTS + 3 * PREFIX_SLOTS);
  localparam logic [AW-1:0] CLR_LAST  = AW'(TOTAL - 1);

  abre_pkg::state_t state, state_next;

  // Weight memory
  logic [WW-1:0] weight_mem [TOTAL];
  logic [WW-1:0] weight_rd;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [AW-1:0] clr_addr;

  // Request held for the duration of the transaction
  logic          cmd_q, bit_q;
  logic [CW-1:0] ctx_q;

  // Coder state
  logic [RW-1:0] range;
  logic [LW-1:0] low;
  logic [BW-1:0] cached;
  logic [NW-1:0] pending;
  logic [RW-1:0] split;
  logic [PW-1:0] shift_cnt;

  // Adaptation shifts
  logic [SW-1:0] type_shift, literal_shift, length_prefix_shift;
  logic [SW-1:0] length_suffix_shift, distance_prefix_shift, distance_suffix_shift;

  // Holding stage and output register
  logic          hold_valid;
  logic [BW-1:0] hold_head, hold_fill;
  logic [NW-1:0] hold_count;
  logic          rec_valid, rec_last;
  logic [BW-1:0] rec_head, rec_fill;
  logic [NW-1:0] rec_count;

  // Control
  logic accept, in_range, finish_mode, more, carry, take_cache, emit, out_free;
  logic do_shift, push, push_last, hold_load, hold_clear, coder_init;
  logic clr_last;

  logic [SW-1:0] shift_raw, shift_eff;
  logic [WW-1:0] weight_new;

  assign accept      = bits.valid && bits.ready;
  assign in_range    = bits.context_req < CTX_TOTAL;
  assign finish_mode = (cmd_q == abre_pkg::CMD_FINISH);
  assign carry       = low[LW-1];
  assign take_cache  = (low[RW-1:0] < abre_pkg::LOW_FLUSH_LIMIT) || carry;
  assign emit        = take_cache && (pending != '0);
  assign more        = finish_mode ? (shift_cnt != abre_pkg::FINISH_SHIFTS)
                                   : (range < abre_pkg::RANGE_TOP);
  assign out_free    = !rec_valid || records.ready;
  assign clr_last    = (clr_addr == CLR_LAST);

  assign bits.ready = (state == abre_pkg::ST_IDLE);

  assign records.valid      = rec_valid;
  assign records.head_byte  = rec_head;
  assign records.fill_byte  = rec_fill;
  assign records.byte_count = rec_count;
  assign records.last       = rec_last;

  // Pick the context group's shift; a zero register acts as one
  always_comb begin
    priority if (ctx_q == '0)     shift_raw = type_shift;
    else if (ctx_q < LIT_END)     shift_raw = literal_shift;
    else if (ctx_q < LP_END)      shift_raw = length_prefix_shift;
    else if (ctx_q < LS_END)      shift_raw = length_suffix_shift;
    else if (ctx_q < DP_END)      shift_raw = distance_prefix_shift;
    else                          shift_raw = distance_suffix_shift;
    shift_eff = (shift_raw == '0) ? SW'(1) : shift_raw;
  end

  // Move the weight toward the coded bit
  always_comb begin
    if (bit_q == 1'b0) begin
      weight_new = weight_rd +
                   WW'((abre_pkg::WEIGHT_ONE - {1'b0, weight_rd}) >> shift_eff);
    end else begin
      weight_new = weight_rd - (weight_rd >> shift_eff);
    end
  end

  assign mem_waddr = (state == abre_pkg::ST_CLEAR) ? clr_addr : ctx_q[AW-1:0];
  assign mem_wdata = (state == abre_pkg::ST_CLEAR) ? abre_pkg::WEIGHT_INIT : weight_new;

  // Next state and step controls
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    do_shift   = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    hold_load  = 1'b0;
    hold_clear = 1'b0;
    coder_init = 1'b0;
    unique case (state)
      abre_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_last) state_next = abre_pkg::ST_IDLE;
      end
      abre_pkg::ST_IDLE: begin
        if (accept) begin
          if (bits.cmd == abre_pkg::CMD_FINISH) begin
            state_next = abre_pkg::ST_SHIFT;
          end else if (in_range) begin
            mem_re     = 1'b1;
            state_next = abre_pkg::ST_MUL;
          end
        end
      end
      abre_pkg::ST_MUL: begin
        mem_we     = 1'b1;
        state_next = abre_pkg::ST_UPDATE;
      end
      abre_pkg::ST_UPDATE: begin
        state_next = abre_pkg::ST_SHIFT;
      end
      abre_pkg::ST_SHIFT: begin
        if (more) begin
          // Hold the shift while an emitted record would find no room
          if (!(emit && hold_valid && !out_free)) begin
            do_shift = 1'b1;
            if (emit) begin
              hold_load = 1'b1;
              push      = hold_valid;
            end
          end
        end else if (!(hold_valid && !out_free)) begin
          push       = hold_valid;
          push_last  = 1'b1;
          hold_clear = 1'b1;
          if (finish_mode) begin
            coder_init = 1'b1;
            state_next = abre_pkg::ST_CLEAR;
          end else begin
            state_next = abre_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = abre_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abre_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) weight_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) weight_rd <= weight_mem[bits.context_req[AW-1:0]];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= bits.cmd;
      bit_q <= bits.bit_req;
      ctx_q <= bits.context_req;
    end
    if (state == abre_pkg::ST_MUL) begin
      split <= RW'(range[RW-1:12] * weight_rd);
    end
    if (hold_load) begin
      hold_head  <= cached + BW'(carry);
      hold_fill  <= carry ? abre_pkg::FILL_CARRY : abre_pkg::FILL_NO_CARRY;
      hold_count <= pending;
    end
    if (push) begin
      rec_head  <= hold_head;
      rec_fill  <= hold_fill;
      rec_count <= hold_count;
      rec_last  <= push_last;
    end
  end

  // Control and coder registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr              <= '0;
      shift_cnt             <= '0;
      range                 <= abre_pkg::RANGE_INIT;
      low                   <= '0;
      cached                <= abre_pkg::CACHE_INIT;
      pending               <= '0;
      hold_valid            <= 1'b0;
      rec_valid             <= 1'b0;
      type_shift            <= SW'(4);
      literal_shift         <= SW'(2);
      length_prefix_shift   <= SW'(4);
      length_suffix_shift   <= SW'(4);
      distance_prefix_shift <= SW'(4);
      distance_suffix_shift <= SW'(4);
    end else begin
      if (state == abre_pkg::ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
      end
      if (accept) shift_cnt <= '0;

      if (state == abre_pkg::ST_UPDATE) begin
        if (bit_q == 1'b0) begin
          range <= split;
        end else begin
          range <= range - split;
          low   <= low + {1'b0, split};
        end
      end

      // One byte shift: settle cache and pending run, advance low
      if (do_shift) begin
        shift_cnt <= shift_cnt + 1'b1;
        if (!finish_mode) range <= {range[RW-9:0], 8'h00};
        if (take_cache) begin
          cached  <= low[RW-1:RW-8];
          pending <= NW'(1);
        end else if (pending != abre_pkg::COUNT_MAX) begin
          pending <= pending + 1'b1;
        end
        low <= {1'b0, low[RW-9:0], 8'h00};
      end

      if (coder_init) begin
        range   <= abre_pkg::RANGE_INIT;
        low     <= '0;
        cached  <= abre_pkg::CACHE_INIT;
        pending <= '0;
      end

      if (hold_load)       hold_valid <= 1'b1;
      else if (hold_clear) hold_valid <= 1'b0;

      rec_valid <= push || (rec_valid && !records.ready);

      if (cfg_we) begin
        unique case (cfg_index)
          abre_pkg::REG_TYPE_SHIFT:            type_shift            <= cfg_data;
          abre_pkg::REG_LITERAL_SHIFT:         literal_shift         <= cfg_data;
          abre_pkg::REG_LENGTH_PREFIX_SHIFT:   length_prefix_shift   <= cfg_data;
          abre_pkg::REG_LENGTH_SUFFIX_SHIFT:   length_suffix_shift   <= cfg_data;
          abre_pkg::REG_DISTANCE_PREFIX_SHIFT: distance_prefix_shift <= cfg_data;
          abre_pkg::REG_DISTANCE_SUFFIX_SHIFT: distance_suffix_shift <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // A new transaction starts only once the previous records have left the holding stage
  a_accept_empty_hold: assert property (@(posedge clk) disable iff (rst)
    accept |-> !hold_valid)
    else $error("transaction accepted with a record still held");

  // Never overwrite a record the sink has not taken
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("record pushed over a waiting record");

  // An encoded bit needs at most two byte shifts
  a_encode_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == abre_pkg::ST_SHIFT && !finish_mode) |-> shift_cnt <= abre_pkg::ENCODE_SHIFTS)
    else $error("too many byte shifts for one bit");

  // The split never collapses the range
  a_range_floor: assert property (@(posedge clk) disable iff (rst)
    (state == abre_pkg::ST_SHIFT && !finish_mode) |-> range >= abre_pkg::RANGE_FLOOR)
    else $error("coder range below floor");

  // Adapted weights stay non-zero
  a_weight_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == abre_pkg::ST_MUL) |=> $past(weight_new) != '0)
    else $error("weight adapted to zero");

endmodule

FILE: test/abre_flush_checker.sv
`timescale 1ns / 1ps
// Flush record checker: predicts records from accepted requests and compares them.
module abre_flush_checker #(
  parameter int LITERAL_CONTEXTS = 256,
  parameter int PREFIX_SLOTS     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  abre_bit_if                            bits,
  abre_flush_if                          records,
  input  logic                           cfg_we,
  input  logic [abre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abre_pkg::SHIFT_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             records_seen,
  output int                             items_seen
);

  localparam int CONTEXTS     = LITERAL_CONTEXTS + 4 * PREFIX_SLOTS;
  localparam int GROUPS       = 6;
  localparam int REPORT_LIMIT = 10;

  localparam logic [abre_pkg::SHIFT_W-1:0] GROUP_SHIFT_RESET   = 4'd4;
  localparam logic [abre_pkg::SHIFT_W-1:0] LITERAL_SHIFT_RESET = 4'd2;

  typedef struct packed {
    logic [abre_pkg::BYTE_W-1:0]  head;
    logic [abre_pkg::BYTE_W-1:0]  fill;
    logic [abre_pkg::COUNT_W-1:0] count;
    logic                         last;
  } flush_rec_t;

  logic [abre_pkg::SHIFT_W-1:0]  shift_of [GROUPS];
  logic [abre_pkg::RANGE_W-1:0]  span;
  logic [abre_pkg::LOW_W-1:0]    base;
  logic [abre_pkg::BYTE_W-1:0]   cache;
  logic [abre_pkg::COUNT_W-1:0]  run_len;
  logic [abre_pkg::WEIGHT_W-1:0] weight [CONTEXTS];
  flush_rec_t                    due_q [$];

  task restart_coder();
    span    = abre_pkg::RANGE_INIT;
    base    = '0;
    cache   = abre_pkg::CACHE_INIT;
    run_len = '0;
    for (int i = 0; i < CONTEXTS; i++) weight[i] = abre_pkg::WEIGHT_INIT;
  endtask

  // One byte leaves the top of low; a settled byte releases the cached one
  // together with the run of pending bytes behind it.
  task shift_out_byte();
    logic       carry;
    flush_rec_t rec;
    carry = base[abre_pkg::LOW_W-1];
    if (base[abre_pkg::RANGE_W-1:0] < abre_pkg::LOW_FLUSH_LIMIT || carry) begin
      if (run_len != '0) begin
        rec.head  = cache + carry;
        rec.fill  = abre_pkg::FILL_NO_CARRY + carry;
        rec.count = run_len;
        rec.last  = 1'b0;
        due_q.push_back(rec);
      end
      run_len = '0;
      cache   = base[31:24];
    end
    if (run_len != abre_pkg::COUNT_MAX) run_len++;
    base = {1'b0, base[23:0], 8'h00};
  endtask

  function automatic int adapt_rate(int ctx);
    abre_pkg::cfg_reg_t r;
    int                 s;
    if (ctx == 0) r = abre_pkg::REG_TYPE_SHIFT;
    else if (ctx < LITERAL_CONTEXTS) r = abre_pkg::REG_LITERAL_SHIFT;
    else r = abre_pkg::cfg_reg_t'(abre_pkg::REG_LENGTH_PREFIX_SHIFT +
                                  (ctx - LITERAL_CONTEXTS) / PREFIX_SLOTS);
    s = shift_of[r];
    // a zero shift behaves as one
    return (s == 0) ? 1 : s;
  endfunction

  task encode_request(input logic c, input logic b, input logic [abre_pkg::CTX_W-1:0] ctx);
    int                           s;
    int                           w;
    int                           queued;
    logic [abre_pkg::RANGE_W-1:0] split;
    queued = due_q.size();
    if (c == abre_pkg::CMD_FINISH) begin
      repeat (abre_pkg::FINISH_SHIFTS) shift_out_byte();
      restart_coder();
    end else if (ctx < CONTEXTS) begin
      s     = adapt_rate(ctx);
      w     = weight[ctx];
      split = (span >> abre_pkg::WEIGHT_W) * weight[ctx];
      if (b == 1'b0) begin
        span = split;
        w    = w + ((int'(abre_pkg::WEIGHT_ONE) - w) >> s);
      end else begin
        span = span - split;
        base = base + split;
        w    = w - (w >> s);
      end
      weight[ctx] = w[abre_pkg::WEIGHT_W-1:0];
      while (span < abre_pkg::RANGE_TOP) begin
        span = span << 8;
        shift_out_byte();
      end
    end
    if (due_q.size() > queued) due_q[due_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    flush_rec_t want;
    if (rst) begin
      foreach (shift_of[i]) shift_of[i] = GROUP_SHIFT_RESET;
      shift_of[abre_pkg::REG_LITERAL_SHIFT] = LITERAL_SHIFT_RESET;
      restart_coder();
      due_q.delete();
    end else begin
      if (cfg_we && cfg_index <= abre_pkg::REG_DISTANCE_SUFFIX_SHIFT)
        shift_of[cfg_index] = cfg_data;
      // compare before predicting: a record never belongs to a request taken at the same edge
      if (records.valid && records.ready) begin
        records_seen++;
        if (due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected flush record head %h fill %h count %0d last %b", $time,
                     records.head_byte, records.fill_byte, records.byte_count, records.last);
        end else begin
          want = due_q.pop_front();
          if (records.head_byte !== want.head || records.fill_byte !== want.fill ||
              records.byte_count !== want.count || records.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: flush record expected head %h fill %h count %0d last %b",
                       $time, want.head, want.fill, want.count, want.last);
              $display("%0t:                   got head %h fill %h count %0d last %b",
                       $time, records.head_byte, records.fill_byte, records.byte_count,
                       records.last);
            end
          end
        end
      end
      if (bits.valid && bits.ready) begin
        items_seen++;
        encode_request(bits.cmd, bits.bit_req, bits.context_req);
      end
    end
    outstanding = due_q.size();
  end

endmodule

FILE: test/adaptive_binary_range_encoder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the adaptive binary range encoder: stimulus, settings and verdict.
module adaptive_binary_range_encoder_tb;

  localparam int CW              = abre_pkg::CTX_W;
  localparam int SW              = abre_pkg::SHIFT_W;
  localparam int CONTEXTS        = 384;
  localparam int CTX_LIMIT       = (1 << CW) - 1;
  localparam int PHASE_ITEMS     = 95;
  // a finish is followed by a weight clearing pass over every context
  localparam int SETTLE_CYCLES   = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PERCENT    = 28;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [abre_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [SW-1:0]                  cfg_data;

  abre_bit_if   bits ();
  abre_flush_if records ();

  int mismatches;
  int outstanding;
  int records_seen;
  int items_seen;
  int finishes;
  int ignored;
  int phases;
  bit quiet;      // no idling on either side while set
  bit stall_req;  // ask the receiver for its long hold-off

  adaptive_binary_range_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .bits      (bits),
    .records   (records),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  abre_flush_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .bits         (bits),
    .records      (records),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .records_seen (records_seen),
    .items_seen   (items_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #40ms;
    $display("adaptive_binary_range_encoder_tb: errors");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request so that the
  // holding stages fill and the encoder has to stall its request channel.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    records.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        records.ready <= 1'b0;
      end else if (stall_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        records.ready <= 1'b0;
      end else begin
        records.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Offer one request, idling first at random, and hold it until it is taken.
  // Entered and left at a falling edge.
  task offer(input logic c, input logic b, input logic [CW-1:0] ctx);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      bits.valid <= 1'b0;
      @(negedge clk);
    end
    bits.valid       <= 1'b1;
    bits.cmd         <= c;
    bits.bit_req     <= b;
    bits.context_req <= ctx;
    do @(posedge clk); while (!bits.ready);
    @(negedge clk);
    if (c == abre_pkg::CMD_FINISH) finishes++;
    else if (ctx >= CONTEXTS) ignored++;
  endtask

  // Drop valid, drain every expected record, then let a finish and its clearing
  // pass run out before anything touches the shift registers.
  task settle();
    bits.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all six adaptation shifts, lowest nibble to the type context's group.
  task program_shifts(input logic [6*SW-1:0] v);
    abre_pkg::cfg_reg_t r;
    r = abre_pkg::REG_TYPE_SHIFT;
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= v[r*SW +: SW];
      @(negedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  // Group edges, out-of-range contexts, a run of ones on one context and
  // back-to-back finishes (the second starts from an empty coder).
  task directed_items();
    offer(abre_pkg::CMD_ENCODE, 1'b0, 9'd0);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd0);
    offer(abre_pkg::CMD_ENCODE, 1'b0, 9'd1);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd255);
    offer(abre_pkg::CMD_ENCODE, 1'b0, 9'd256);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd287);
    offer(abre_pkg::CMD_ENCODE, 1'b0, 9'd288);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd319);
    offer(abre_pkg::CMD_ENCODE, 1'b0, 9'd320);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd351);
    offer(abre_pkg::CMD_ENCODE, 1'b0, 9'd352);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd383);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd384);
    offer(abre_pkg::CMD_ENCODE, 1'b0, 9'd511);
    repeat (4) offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd7);
    offer(abre_pkg::CMD_FINISH, 1'b1, 9'd511);
    offer(abre_pkg::CMD_FINISH, 1'b0, 9'd0);
    offer(abre_pkg::CMD_ENCODE, 1'b1, 9'd7);
    offer(abre_pkg::CMD_FINISH, 1'b0, 9'd0);
  endtask

  // Mostly well-formed encodes with skewed bits so that weights adapt and a
  // wrong guess costs several byte shifts; some finishes and ignored contexts.
  task random_items(input int count);
    logic [CW-1:0] ctx;
    logic          b;
    int            roll;
    int            sel;
    int            taken;
    taken = 0;
    while (taken < count) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        offer(abre_pkg::CMD_FINISH, 1'($urandom_range(1)), CW'($urandom_range(CTX_LIMIT)));
        taken++;
      end else if (roll < 9) begin
        // out-of-range context: does not advance the item count
        offer(abre_pkg::CMD_ENCODE, 1'($urandom_range(1)),
              CW'($urandom_range(CTX_LIMIT, CONTEXTS)));
      end else begin
        sel = $urandom_range(9);
        if (sel == 0) ctx = '0;
        else if (sel < 6) ctx = CW'($urandom_range(255, 1));
        else ctx = CW'($urandom_range(CONTEXTS - 1, 256));
        if (roll < 30) b = 1'($urandom_range(1));
        else b = ($urandom_range(9) < 8) ? ctx[0] : ~ctx[0];
        offer(abre_pkg::CMD_ENCODE, b, ctx);
        taken++;
      end
    end
  endtask

  initial begin
    logic [6*SW-1:0] mixed;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = abre_pkg::REG_TYPE_SHIFT;
    cfg_data         = '0;
    bits.valid       = 1'b0;
    bits.cmd         = abre_pkg::CMD_ENCODE;
    bits.bit_req     = 1'b0;
    bits.context_req = '0;
    quiet            = 1'b0;
    stall_req        = 1'b0;
    finishes         = 0;
    ignored          = 0;
    phases           = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset shifts first, then the extremes, then zeros
    directed_items();
    settle();

    program_shifts({6{4'd1}});
    random_items(PHASE_ITEMS);
    settle();

    // slowest adaptation, with both sides running flat out
    quiet <= 1'b1;
    program_shifts({6{4'd15}});
    random_items(PHASE_ITEMS);
    settle();
    quiet <= 1'b0;

    program_shifts({6{4'd0}});
    random_items(PHASE_ITEMS);
    settle();

    // mixed shifts per group, with the receiver's long hold-off in this phase
    for (int i = 0; i < 6; i++) mixed[i*SW +: SW] = SW'($urandom_range(15));
    program_shifts(mixed);
    stall_req <= 1'b1;
    random_items(PHASE_ITEMS);
    settle();

    $display("covered %0d requests (%0d finishes, %0d out-of-range contexts)",
             items_seen, finishes, ignored);
    $display("over %0d shift settings and compared %0d flush records", phases, records_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("adaptive_binary_range_encoder_tb: clean");
    end else begin
      $display("adaptive_binary_range_encoder_tb: errors");
    end
    $finish;
  end

endmodule
